// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the clipper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define LSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/lsc_pkg.sv =====
// Package with the shared constants and types of the line segment clipper.
package lsc_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int T_FRACTION_BITS_DEF = 16;
    localparam int CFG_INDEX_WIDTH     = 3;

    localparam int WIN_LEFT_RST   = -100;
    localparam int WIN_BOTTOM_RST = -100;
    localparam int WIN_RIGHT_RST  = 100;
    localparam int WIN_TOP_RST    = 100;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LEFT,
        CFG_BOTTOM,
        CFG_RIGHT,
        CFG_TOP
    } t_cfg_reg;

    typedef struct packed {
        logic p_zero;
        logic p_neg;
        logic q_neg;
    } t_ratio_flags;

endpackage

// ===== hdl/lsc_div.sv =====
// Pipelined ratio unit: q * 2^F / p, one quotient bit per stage, directed rounding.
module lsc_div #(
    parameter int COORD_WIDTH     = lsc_pkg::COORD_WIDTH_DEF,
    parameter int T_FRACTION_BITS = lsc_pkg::T_FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_ce,
    input  logic signed [COORD_WIDTH:0]     i_p,
    input  logic signed [COORD_WIDTH:0]     i_q,
    output logic signed [T_FRACTION_BITS+2:0] o_r,
    output lsc_pkg::t_ratio_flags           o_flags
);

    localparam int W = COORD_WIDTH;
    localparam int F = T_FRACTION_BITS;
    localparam logic [F+1:0] SAT_MAG = (F+2)'(2**F + 2);

    logic [W:0]                  r_a0;
    logic [W:0]                  r_b0;
    lsc_pkg::t_ratio_flags       r_fl0;

    logic [W:0]                  r_rem  [0:F];
    logic [W:0]                  r_b    [0:F];
    logic [F:0]                  r_quo  [0:F];
    logic                        r_sat  [0:F];
    lsc_pkg::t_ratio_flags       r_fl   [0:F];

    logic [W+1:0]                w_twob;
    logic                        w_sat;
    logic                        w_ige;
    logic [F+1:0]                w_mag;
    logic                        w_bump;
    logic signed [F+2:0]         w_smag;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a0         <= i_q[W] ? (W+1)'(-i_q) : i_q;
            r_b0         <= i_p[W] ? (W+1)'(-i_p) : i_p;
            r_fl0.p_zero <= (i_p == '0);
            r_fl0.p_neg  <= i_p[W];
            r_fl0.q_neg  <= i_q[W];
        end
    end

    assign w_twob = {r_b0, 1'b0};
    assign w_sat  = ({1'b0, r_a0} >= w_twob);
    assign w_ige  = (r_a0 >= r_b0);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= w_ige ? (r_a0 - r_b0) : r_a0;
            r_b[0]   <= r_b0;
            r_quo[0] <= {{F{1'b0}}, w_ige};
            r_sat[0] <= w_sat;
            r_fl[0]  <= r_fl0;
        end
    end

    for (genvar k = 1; k <= F; k++) begin : g_step
        logic [W+1:0] w_rem2;
        logic         w_ge;
        logic [W+1:0] w_diff;

        assign w_rem2 = {r_rem[k-1], 1'b0};
        assign w_ge   = (w_rem2 >= {1'b0, r_b[k-1]});
        assign w_diff = w_rem2 - {1'b0, r_b[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= w_ge ? w_diff[W:0] : w_rem2[W:0];
                r_b[k]   <= r_b[k-1];
                r_quo[k] <= {r_quo[k-1][F-1:0], w_ge};
                r_sat[k] <= r_sat[k-1];
                r_fl[k]  <= r_fl[k-1];
            end
        end
    end

    // A remainder on a negative numerator rounds the magnitude up in both directions.
    assign w_bump = (r_rem[F] != '0) && r_fl[F].q_neg;
    assign w_mag  = r_sat[F] ? SAT_MAG : ({1'b0, r_quo[F]} + (F+2)'(w_bump));
    assign w_smag = signed'({1'b0, w_mag});

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_r     <= (r_fl[F].q_neg ^ r_fl[F].p_neg) ? -w_smag : w_smag;
            o_flags <= r_fl[F];
        end
    end

endmodule

// ===== hdl/lsc_interp.sv =====
// Endpoint interpolation: base + d * t, rounded to nearest with ties upward.
module lsc_interp #(
    parameter int COORD_WIDTH     = lsc_pkg::COORD_WIDTH_DEF,
    parameter int T_FRACTION_BITS = lsc_pkg::T_FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic                          i_ok,
    input  logic signed [COORD_WIDTH-1:0] i_base,
    input  logic signed [COORD_WIDTH:0]   i_d,
    input  logic [T_FRACTION_BITS:0]      i_t,
    output logic [COORD_WIDTH-1:0]        o_val
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = T_FRACTION_BITS;
    localparam int PW = W + F + 3;

    logic signed [PW-1:0]  r_prod;
    logic signed [W-1:0]   r_base;
    logic                  r_ok;
    logic signed [PW-1:0]  w_sum;
    logic signed [PW-1:0]  w_val;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod <= PW'(i_d) * PW'(signed'({1'b0, i_t}));
            r_base <= i_base;
            r_ok   <= i_ok;
        end
    end

    assign w_sum = r_prod + PW'(2**(F-1));
    assign w_val = (w_sum >>> F) + PW'(r_base);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_val <= r_ok ? w_val[W-1:0] : '0;
        end
    end

endmodule

// ===== hdl/line_segment_clipper.sv =====
// Top level of the Liang-Barsky line segment clipper.
//
// Segments arrive on the slave stream, one per transfer, and each gives exactly
// one result transfer on the master stream in the same order. The result
// carries the visible flag in tuser and the clipped endpoints in tdata; a
// rejected segment returns zero endpoints.
// The clip window lives in four registers written through the plain write
// port (left, bottom, right, top); write them only while no segment is in
// flight.
// The latency is set by the ratio dividers, which resolve one quotient bit per
// stage. One segment is accepted every cycle while the pipeline is not held
// by a receiver stall.
// When the receiver stalls, the whole pipeline holds and s_axis_tready falls
// only while the output register is full; nothing is lost or repeated.
// Synchronous reset empties the pipeline and returns the window to
// (-100, -100) .. (100, 100).
`include "assert_macros.svh"

module line_segment_clipper #(
    parameter int COORD_WIDTH     = lsc_pkg::COORD_WIDTH_DEF,
    parameter int T_FRACTION_BITS = lsc_pkg::T_FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lsc_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                 i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y from the lowest bit up
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // visible
    output logic                                   m_axis_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int F      = T_FRACTION_BITS;
    localparam int DATA_W = ((4*W+7)/8)*8;
    localparam int NST    = F + 7;
    localparam int CARRY  = F + 5;
    localparam logic signed [F+2:0] T_ONE = (F+3)'(2**F);

    logic signed [W-1:0] r_left, r_bottom, r_right, r_top;

    logic [NST-1:0]      r_vld;
    logic                w_ce;

    logic signed [W-1:0] w_sx, w_sy, w_ex, w_ey;
    logic signed [W:0]   w_dx, w_dy;

    logic signed [W:0]   r_p [0:3];
    logic signed [W:0]   r_q [0:3];

    logic signed [W-1:0] r_x0 [0:CARRY-1];
    logic signed [W-1:0] r_y0 [0:CARRY-1];
    logic signed [W:0]   r_dx [0:CARRY-1];
    logic signed [W:0]   r_dy [0:CARRY-1];

    logic signed [F+2:0]   w_r  [0:3];
    lsc_pkg::t_ratio_flags w_fl [0:3];

    logic signed [F+2:0] w_in_c  [0:3];
    logic signed [F+2:0] w_out_c [0:3];
    logic signed [F+2:0] w_in01, w_in23, w_out01, w_out23;
    logic                w_edge_ok;

    logic signed [F+2:0] n_tin, n_tout;
    logic                n_ok;
    logic [F:0]          r_tin, r_tout;
    logic                r_ok;
    logic [1:0]          r_vis;

    logic [W-1:0]        w_csx, w_csy, w_cex, w_cey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= W'(lsc_pkg::WIN_LEFT_RST);
            r_bottom <= W'(lsc_pkg::WIN_BOTTOM_RST);
            r_right  <= W'(lsc_pkg::WIN_RIGHT_RST);
            r_top    <= W'(lsc_pkg::WIN_TOP_RST);
        end else if (i_cfg_we) begin
            case (lsc_pkg::t_cfg_reg'(i_cfg_index))
                lsc_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                lsc_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data;
                lsc_pkg::CFG_RIGHT:  r_right  <= i_cfg_data;
                lsc_pkg::CFG_TOP:    r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_ce          = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = w_ce;
    assign m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    assign w_sx = s_axis_tdata[0*W +: W];
    assign w_sy = s_axis_tdata[1*W +: W];
    assign w_ex = s_axis_tdata[2*W +: W];
    assign w_ey = s_axis_tdata[3*W +: W];
    assign w_dx = (W+1)'(w_ex) - (W+1)'(w_sx);
    assign w_dy = (W+1)'(w_ey) - (W+1)'(w_sy);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_p[0] <= -w_dx;
            r_q[0] <= (W+1)'(w_sx) - (W+1)'(r_left);
            r_p[1] <= w_dx;
            r_q[1] <= (W+1)'(r_right) - (W+1)'(w_sx);
            r_p[2] <= -w_dy;
            r_q[2] <= (W+1)'(w_sy) - (W+1)'(r_bottom);
            r_p[3] <= w_dy;
            r_q[3] <= (W+1)'(r_top) - (W+1)'(w_sy);
            r_x0[0] <= w_sx;
            r_y0[0] <= w_sy;
            r_dx[0] <= w_dx;
            r_dy[0] <= w_dy;
            for (int k = 1; k < CARRY; k++) begin
                r_x0[k] <= r_x0[k-1];
                r_y0[k] <= r_y0[k-1];
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
        end
    end

    for (genvar e = 0; e < 4; e++) begin : g_edge
        lsc_div #(
            .COORD_WIDTH     (W),
            .T_FRACTION_BITS (F)
        ) u_div (
            .i_clk   (i_clk),
            .i_ce    (w_ce),
            .i_p     (r_p[e]),
            .i_q     (r_q[e]),
            .o_r     (w_r[e]),
            .o_flags (w_fl[e])
        );
    end

    // Each edge gives an entry or an exit bound. The segment survives when no parallel edge
    // has its start outside and the largest entry bound does not pass the smallest exit bound.
    always_comb begin
        w_edge_ok = 1'b1;
        for (int e = 0; e < 4; e++) begin
            w_in_c[e]  = '0;
            w_out_c[e] = T_ONE;
            if (w_fl[e].p_zero) begin
                if (w_fl[e].q_neg) w_edge_ok = 1'b0;
            end else if (w_fl[e].p_neg) begin
                if (w_r[e] > 0) w_in_c[e] = w_r[e];
            end else begin
                if (w_r[e] < T_ONE) w_out_c[e] = w_r[e];
            end
        end
        w_in01  = (w_in_c[0] > w_in_c[1]) ? w_in_c[0] : w_in_c[1];
        w_in23  = (w_in_c[2] > w_in_c[3]) ? w_in_c[2] : w_in_c[3];
        w_out01 = (w_out_c[0] < w_out_c[1]) ? w_out_c[0] : w_out_c[1];
        w_out23 = (w_out_c[2] < w_out_c[3]) ? w_out_c[2] : w_out_c[3];
        n_tin   = (w_in01 > w_in23) ? w_in01 : w_in23;
        n_tout  = (w_out01 < w_out23) ? w_out01 : w_out23;
        n_ok    = w_edge_ok && (n_tin <= n_tout);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_tin  <= n_tin[F:0];
            r_tout <= n_tout[F:0];
            r_ok   <= n_ok;
            r_vis  <= {r_vis[0], r_ok};
        end
    end

    lsc_interp #(.COORD_WIDTH(W), .T_FRACTION_BITS(F)) u_sx (
        .i_clk (i_clk), .i_ce (w_ce), .i_ok (r_ok),
        .i_base (r_x0[CARRY-1]), .i_d (r_dx[CARRY-1]), .i_t (r_tin), .o_val (w_csx)
    );
    lsc_interp #(.COORD_WIDTH(W), .T_FRACTION_BITS(F)) u_sy (
        .i_clk (i_clk), .i_ce (w_ce), .i_ok (r_ok),
        .i_base (r_y0[CARRY-1]), .i_d (r_dy[CARRY-1]), .i_t (r_tin), .o_val (w_csy)
    );
    lsc_interp #(.COORD_WIDTH(W), .T_FRACTION_BITS(F)) u_ex (
        .i_clk (i_clk), .i_ce (w_ce), .i_ok (r_ok),
        .i_base (r_x0[CARRY-1]), .i_d (r_dx[CARRY-1]), .i_t (r_tout), .o_val (w_cex)
    );
    lsc_interp #(.COORD_WIDTH(W), .T_FRACTION_BITS(F)) u_ey (
        .i_clk (i_clk), .i_ce (w_ce), .i_ok (r_ok),
        .i_base (r_y0[CARRY-1]), .i_d (r_dy[CARRY-1]), .i_t (r_tout), .o_val (w_cey)
    );

    assign m_axis_tdata = DATA_W'({w_cey, w_cex, w_csy, w_csx});
    assign m_axis_tuser = r_vis[1];

    `LSC_ASSERT(a_reject_zero, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "rejected segment has non-zero endpoints")
    `LSC_ASSERT(a_param_order, i_clk, i_rst_n, (r_vld[F+4] && r_ok) |-> (r_tin <= r_tout), "entry parameter exceeds exit parameter")
    `LSC_ASSERT(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n) |-> !m_axis_tvalid, "result valid straight after reset")

endmodule

// ===== sim/lsc_checker.sv =====
// Checker that predicts clipped segments and compares them with the block's results.
`timescale 1ns / 1ps

module lsc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_seg_valid,
    input  logic        i_seg_ready,
    input  logic [63:0] i_seg_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [63:0] i_res_data,
    input  logic        i_res_visible,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic        visible;
        logic [63:0] ends;
    } t_clip;

    t_clip       clip_queue[$];
    logic signed [15:0] win_left, win_bottom, win_right, win_top;

    function automatic longint div_floor(longint n, longint d);
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic bit apply_edge(longint p, longint q, ref longint t_lo, ref longint t_hi);
        longint r;
        if (p == 0) return q >= 0;
        if (p > 0) begin
            r = div_floor(q * 65536, p);
            if (r < t_hi) t_hi = r;
            return !(r < t_lo);
        end
        r = -div_floor(q * 65536, -p);
        if (r > t_lo) t_lo = r;
        return !(r > t_hi);
    endfunction

    function automatic logic [15:0] lerp(longint base, longint d, longint t);
        longint v;
        v = base + div_floor(d * t + 32768, 65536);
        return v[15:0];
    endfunction

    function automatic t_clip clip_segment(logic [63:0] seg);
        longint x0, y0, dx, dy, t_lo, t_hi;
        t_clip c;
        x0 = $signed(seg[15:0]);
        y0 = $signed(seg[31:16]);
        dx = longint'($signed(seg[47:32])) - x0;
        dy = longint'($signed(seg[63:48])) - y0;
        t_lo = 0;
        t_hi = 65536;
        c.visible = 1'b0;
        c.ends = '0;
        if (apply_edge(-dx, x0 - win_left, t_lo, t_hi)
            && apply_edge(dx, win_right - x0, t_lo, t_hi)
            && apply_edge(-dy, y0 - win_bottom, t_lo, t_hi)
            && apply_edge(dy, win_top - y0, t_lo, t_hi)) begin
            c.visible = 1'b1;
            c.ends = {lerp(y0, dy, t_hi), lerp(x0, dx, t_hi),
                      lerp(y0, dy, t_lo), lerp(x0, dx, t_lo)};
        end
        return c;
    endfunction

    assign o_pending = clip_queue.size();

    always @(posedge i_clk) begin
        t_clip want;
        if (!i_rst_n) begin
            win_left <= 16'(lsc_pkg::WIN_LEFT_RST);
            win_bottom <= 16'(lsc_pkg::WIN_BOTTOM_RST);
            win_right <= 16'(lsc_pkg::WIN_RIGHT_RST);
            win_top <= 16'(lsc_pkg::WIN_TOP_RST);
            clip_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (lsc_pkg::t_cfg_reg'(i_cfg_index))
                    lsc_pkg::CFG_LEFT: win_left <= i_cfg_data;
                    lsc_pkg::CFG_BOTTOM: win_bottom <= i_cfg_data;
                    lsc_pkg::CFG_RIGHT: win_right <= i_cfg_data;
                    lsc_pkg::CFG_TOP: win_top <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_seg_valid && i_seg_ready) clip_queue.push_back(clip_segment(i_seg_data));
            if (i_res_valid && i_res_ready) begin
                if (clip_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result transfer %h", i_res_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = clip_queue.pop_front();
                    if (want.visible !== i_res_visible || want.ends !== i_res_data) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %b %h, got %b %h",
                                     want.visible, want.ends, i_res_visible, i_res_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
// Top of the clipper testbench: stimulus, window settings and the verdict.
`timescale 1ns / 1ps

module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_idle = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    line_segment_clipper dut (.*);

    lsc_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_seg_valid(s_axis_tvalid), .i_seg_ready(s_axis_tready), .i_seg_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .i_res_data(m_axis_tdata),
        .i_res_visible(m_axis_tuser), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom());
            default: return 16'($signed($urandom_range(600)) - 300);
        endcase
    endfunction

    task automatic send_segment(logic [15:0] x0, y0, x1, y1);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y1, x1, y0, x0};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_window(logic [15:0] l, b, r, t);
        logic [15:0] vals[4];
        vals = '{l, b, r, t};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= 3'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        // An index beyond the window registers must be ignored.
        i_cfg_index <= 3'd6;
        i_cfg_data <= 16'($urandom());
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_segments(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0)
                send_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            else if ($urandom_range(3) == 0) begin
                logic [15:0] px = pick_coord(), py = pick_coord();
                send_segment(px, py, px, py);
            end else
                send_segment(16'($signed($urandom_range(600)) - 300),
                             16'($signed($urandom_range(600)) - 300),
                             16'($signed($urandom_range(600)) - 300),
                             16'($signed($urandom_range(600)) - 300));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 27;
        recv_idle = 58;
        send_segment(16'hff38, 16'h0000, 16'h00c8, 16'h0000);
        send_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_segment(16'h0064, 16'h0064, 16'h0064, 16'h0064);
        send_segment(16'h00c8, 16'h00c8, 16'h00c8, 16'h00c8);
        send_segment(16'h0000, 16'hff38, 16'h0000, 16'h00c8);
        send_segment(16'h00c8, 16'h0000, 16'h0190, 16'h0000);
        send_segment(16'h0000, 16'h00c8, 16'h0000, 16'h0190);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_segment(16'h0003, 16'h0001, 16'h0000, 16'h0000);
        send_segment(16'hff9c, 16'hff9c, 16'h0064, 16'h0064);
        send_segment(16'hff00, 16'h0050, 16'h0050, 16'hff00);
        drain();
        write_window(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_segment(16'h7fff, 16'h0000, 16'h8000, 16'hffff);
        random_segments(200);
        drain();
        write_window(16'h0064, 16'h0000, 16'hff9c, 16'h0000);
        random_segments(100);
        send_idle = 58;
        recv_idle = 27;
        drain();
        write_window(16'hfff6, 16'hffec, 16'h0005, 16'h0007);
        random_segments(250);
        send_idle = 0;
        recv_idle = 0;
        drain();
        write_window(16'hff9c, 16'hff9c, 16'h0064, 16'h0064);
        random_segments(450);
        drain();
        if (fail_count == 0) begin
            $display("line_segment_clipper regression: pass");
        end else begin
            $display("line_segment_clipper regression: fail");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("line_segment_clipper regression: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lsc_pkg.sv
hdl/lsc_div.sv
hdl/lsc_interp.sv
hdl/line_segment_clipper.sv
sim/lsc_checker.sv
sim/tb.sv
